[sv/bsr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared constants and controller/datapath interface types for the byte
// stream reassembler.
// ----------------------------------------------------------------------------
package bsr_pkg;

    // reorder window depth in bytes
    localparam int WINDOW = 64;

    // field widths
    localparam int POS_W  = 32;
    localparam int BYTE_W = 8;
    localparam int HELD_W = 7;

    // slot index and in-window offset widths
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int OFF_W  = $clog2(WINDOW + 1);

    // packed stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic capture;      // latch the incoming beat
        logic store;        // update eof and write the byte into the window
        logic rd_head;      // read the window slot at the head
        logic emit_byte;    // release the head byte as a result
        logic emit_status;  // finish the item with a status-only result
    } t_dp_cmd;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic at_end;       // next position has reached the end position
        logic head_valid;   // head slot holds a byte
        logic more;         // another byte follows the head in this run
        logic out_free;     // output register can take a result
    } t_dp_status;

endpackage : bsr_pkg
`default_nettype wire

[sv/bsr_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_ctrl
// Sequencer for the reassembler: accepts one beat, stores it, then drains
// contiguous window bytes into the output register, one per cycle while free.
// ----------------------------------------------------------------------------
module bsr_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  bsr_pkg::t_dp_status  i_status,
    output bsr_pkg::t_dp_cmd     o_cmd
);
    import bsr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_STORE = 4'b0010,
        S_READ  = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = S_READ;
            end
            S_READ: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_DRAIN;
            end
            S_DRAIN: begin
                if (i_status.out_free) begin
                    if (i_status.at_end || !i_status.head_valid) begin
                        o_cmd.emit_status = 1'b1;
                        n_state           = S_IDLE;
                    end else begin
                        o_cmd.emit_byte = 1'b1;
                        if (!i_status.more) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // a beat is only taken while the sequencer is idle
    a_capture_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |-> (r_state == S_IDLE))
        else $error("capture outside idle");

    // a store is always followed by the head read
    a_store_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.store |=> o_cmd.rd_head)
        else $error("store not followed by head read");

    // a run ends by going idle after its last result
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_status || (o_cmd.emit_byte && !i_status.more))
            |=> (r_state == S_IDLE))
        else $error("run did not end after last result");
`endif

endmodule : bsr_ctrl
`default_nettype wire

[sv/bsr_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_dp
// Reassembler datapath: window memory, per-slot valid bits, stream position
// tracking, end-of-stream tracking and the result output register.
// ----------------------------------------------------------------------------
module bsr_dp (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  bsr_pkg::t_dp_cmd              i_cmd,
    output bsr_pkg::t_dp_status           o_status,
    input  wire [bsr_pkg::POS_W-1:0]      i_stream_index,
    input  wire [bsr_pkg::BYTE_W-1:0]     i_data_byte,
    input  wire                           i_has_byte,
    input  wire                           i_eof_flag,
    input  wire                           i_out_ready,
    output logic                          o_out_valid,
    output logic [bsr_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                          o_byte_valid,
    output logic [bsr_pkg::POS_W-1:0]     o_ack_position,
    output logic [bsr_pkg::HELD_W-1:0]    o_held_count,
    output logic                          o_stream_ended,
    output logic                          o_last_of_run
);
    import bsr_pkg::*;

    // window storage
    logic [BYTE_W-1:0] r_mem [WINDOW];
    logic [BYTE_W-1:0] r_rd_data;
    logic [WINDOW-1:0] r_valid;
    logic [WINDOW-1:0] n_valid;

    // stream state
    logic [POS_W-1:0]  r_next;
    logic [POS_W-1:0]  n_next;
    logic [SLOT_W-1:0] r_head;
    logic [SLOT_W-1:0] n_head;
    logic [HELD_W-1:0] r_held;
    logic [HELD_W-1:0] n_held;
    logic              r_eof_known;
    logic              n_eof_known;
    logic [OFF_W-1:0]  r_eof_off;
    logic [OFF_W-1:0]  n_eof_off;
    logic              r_ended;
    logic              n_ended;

    // captured beat
    logic [POS_W-1:0]  r_off;
    logic [BYTE_W-1:0] r_data;
    logic              r_has;
    logic              r_eof;

    // output register
    logic              r_o_valid;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_bvalid;
    logic [POS_W-1:0]  r_o_ack;
    logic [HELD_W-1:0] r_o_held;
    logic              r_o_ended;
    logic              r_o_last;

    // combinational helpers
    logic [POS_W-1:0]  end_off;
    logic              eof_ok;
    logic              known_upd;
    logic [OFF_W-1:0]  eoff_upd;
    logic              in_win;
    logic              keep;
    logic [SLOT_W:0]   slot_sum;
    logic [SLOT_W-1:0] wr_slot;
    logic              wr_en;
    logic [SLOT_W-1:0] head_inc;
    logic              at_end;
    logic              end_next;
    logic              more;
    logic              out_free;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;

    // store decision for the captured beat
    always_comb begin
        end_off   = r_off + POS_W'(r_has);
        eof_ok    = r_eof && (end_off <= POS_W'(WINDOW));
        known_upd = r_eof_known | eof_ok;
        eoff_upd  = eof_ok ? end_off[OFF_W-1:0] : r_eof_off;
        in_win    = r_off < POS_W'(WINDOW);
        keep      = r_has && in_win && !(known_upd && (r_off[OFF_W-1:0] >= eoff_upd));
        slot_sum  = {1'b0, r_head} + {1'b0, r_off[SLOT_W-1:0]};
        if (slot_sum >= (SLOT_W+1)'(WINDOW)) begin
            slot_sum = slot_sum - (SLOT_W+1)'(WINDOW);
        end
        wr_slot   = slot_sum[SLOT_W-1:0];
        wr_en     = i_cmd.store && !r_ended && keep;
    end

    // drain lookahead
    always_comb begin
        head_inc = (r_head == SLOT_W'(WINDOW - 1)) ? '0 : r_head + SLOT_W'(1);
        at_end   = r_eof_known && (r_eof_off == '0);
        end_next = r_eof_known && (r_eof_off == OFF_W'(1));
        more     = !end_next && r_valid[head_inc];
        out_free = !r_o_valid || i_out_ready;
        rd_en    = i_cmd.rd_head || i_cmd.emit_byte;
        rd_addr  = i_cmd.rd_head ? r_head : head_inc;
    end

    always_comb begin
        o_status.at_end     = at_end;
        o_status.head_valid = r_valid[r_head];
        o_status.more       = more;
        o_status.out_free   = out_free;
    end

    // window memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_slot] <= r_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // capture of the incoming beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_off  <= i_stream_index - r_next;
            r_data <= i_data_byte;
            r_has  <= i_has_byte;
            r_eof  <= i_eof_flag;
        end
    end

    // next stream state
    always_comb begin
        n_valid     = r_valid;
        n_next      = r_next;
        n_head      = r_head;
        n_held      = r_held;
        n_eof_known = r_eof_known;
        n_eof_off   = r_eof_off;
        n_ended     = r_ended;
        if (i_cmd.store && !r_ended) begin
            n_eof_known = known_upd;
            n_eof_off   = eoff_upd;
            if (wr_en && !r_valid[wr_slot]) begin
                n_valid[wr_slot] = 1'b1;
                n_held           = r_held + HELD_W'(1);
            end
        end
        if (i_cmd.emit_byte) begin
            n_valid[r_head] = 1'b0;
            n_next          = r_next + POS_W'(1);
            n_head          = head_inc;
            n_eof_off       = r_eof_off - OFF_W'(r_eof_known);
            n_held          = r_held - HELD_W'(1);
            if (end_next) begin
                n_valid = '0;
                n_held  = '0;
                n_ended = 1'b1;
            end
        end
        if (i_cmd.emit_status && at_end) begin
            n_valid = '0;
            n_held  = '0;
            n_ended = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_next      <= '0;
            r_head      <= '0;
            r_held      <= '0;
            r_eof_known <= 1'b0;
            r_eof_off   <= '0;
            r_ended     <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_next      <= n_next;
            r_head      <= n_head;
            r_held      <= n_held;
            r_eof_known <= n_eof_known;
            r_eof_off   <= n_eof_off;
            r_ended     <= n_ended;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit_byte || i_cmd.emit_status) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_byte) begin
            r_o_byte   <= r_rd_data;
            r_o_bvalid <= 1'b1;
            r_o_ack    <= r_next + POS_W'(1);
            r_o_held   <= end_next ? '0 : r_held - HELD_W'(1);
            r_o_ended  <= end_next;
            r_o_last   <= !more;
        end else if (i_cmd.emit_status) begin
            r_o_byte   <= '0;
            r_o_bvalid <= 1'b0;
            r_o_ack    <= r_next;
            r_o_held   <= at_end ? '0 : r_held;
            r_o_ended  <= at_end;
            r_o_last   <= 1'b1;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_out_byte     = r_o_byte;
    assign o_byte_valid   = r_o_bvalid;
    assign o_ack_position = r_o_ack;
    assign o_held_count   = r_o_held;
    assign o_stream_ended = r_o_ended;
    assign o_last_of_run  = r_o_last;

`ifndef NO_ASSERTIONS
    // held count tracks the valid bits
    a_held_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_held))
        else $error("held count out of step with valid bits");

    // a known end never lies beyond the window
    a_eof_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eof_known |-> (r_eof_off <= OFF_W'(WINDOW)))
        else $error("end offset beyond window");

    // a result is only loaded when the output register is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_byte || i_cmd.emit_status) |-> out_free)
        else $error("result overwrote pending output");

    // reaching the end marks the stream ended and empties the window
    a_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_status && at_end) |=> (r_ended && (r_valid == '0)))
        else $error("end not recorded");
`endif

endmodule : bsr_dp
`default_nettype wire

[sv/byte_stream_reassembler_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stream_reassembler_top
// In-order reassembly of a byte stream from position-tagged bytes.
// ----------------------------------------------------------------------------
// Input beats carry one stream byte with its 32-bit position (tdata), a flag
// saying whether a byte is present (tuser) and the end-of-stream mark (tlast).
// Bytes ahead of the next needed position wait in a 64-slot window; when the
// next needed byte is present, it and all contiguous held bytes are released
// in order, one output beat per byte. A beat that releases nothing yields one
// status beat (tuser low). Every output beat carries the ack position, the
// held byte count and the ended flag; tlast marks the final beat of an item.
// After accept the sequencer captures, stores, reads the head slot, then drains;
// the drain runs at one byte per cycle while the output register is free,
// paced by the window memory read port.
// Input is accepted only while the sequencer is idle, even when an output
// beat is still pending. When the receiver stalls, the drain holds.
// Reset empties the window, sets the next position to zero, clears the end
// state and drops any pending output beat.
// ----------------------------------------------------------------------------
module byte_stream_reassembler_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // stream_index[31:0], data_byte[39:32]
    input  wire [bsr_pkg::S_TDATA_W-1:0]       i_s_axis_tdata,
    // has_byte
    input  wire                                i_s_axis_tuser,
    // eof_flag
    input  wire                                i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // out_byte[7:0], ack_position[39:8], held_count[46:40], stream_ended[47]
    output logic [bsr_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    // byte_valid
    output logic                               o_m_axis_tuser,
    // last_of_run
    output logic                               o_m_axis_tlast
);
    import bsr_pkg::*;

    t_dp_cmd           cmd;
    t_dp_status        status;
    logic [BYTE_W-1:0] out_byte;
    logic [POS_W-1:0]  ack_position;
    logic [HELD_W-1:0] held_count;
    logic              stream_ended;

    // sequencer
    bsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // window and stream datapath
    bsr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_stream_index (i_s_axis_tdata[POS_W-1:0]),
        .i_data_byte    (i_s_axis_tdata[POS_W +: BYTE_W]),
        .i_has_byte     (i_s_axis_tuser),
        .i_eof_flag     (i_s_axis_tlast),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_out_byte     (out_byte),
        .o_byte_valid   (o_m_axis_tuser),
        .o_ack_position (ack_position),
        .o_held_count   (held_count),
        .o_stream_ended (stream_ended),
        .o_last_of_run  (o_m_axis_tlast)
    );

    // output beat packing
    assign o_m_axis_tdata = {stream_ended, held_count, ack_position, out_byte};

endmodule : byte_stream_reassembler_top
`default_nettype wire
